@@ rtl/slt_pkg.sv @@
package slt_pkg;

	localparam logic [2:0] MODE_NORMAL  = 3'd0;
	localparam logic [2:0] MODE_DQ      = 3'd1;
	localparam logic [2:0] MODE_SQ      = 3'd2;
	localparam logic [2:0] MODE_AFTERQ  = 3'd3;
	localparam logic [2:0] MODE_HELD_LT = 3'd4;
	localparam logic [2:0] MODE_HELD_GT = 3'd5;

	localparam logic [1:0] KIND_BYTE    = 2'd0;
	localparam logic [1:0] KIND_END     = 2'd1;
	localparam logic [1:0] KIND_LINE_OK = 2'd2;
	localparam logic [1:0] KIND_UNTERM  = 2'd3;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_SPACE  = 8'h20;
	localparam logic [7:0] CH_PIPE   = 8'h7C;
	localparam logic [7:0] CH_LT     = 8'h3C;
	localparam logic [7:0] CH_GT     = 8'h3E;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;

	localparam logic [1:0] MAX_RES = 2'd3;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
	} res_t;

	typedef struct packed {
		logic [1:0]      cnt;
		res_t [2:0]      res;
	} plan_t;

	typedef struct packed {
		logic [2:0] mode;
		logic       topen;
	} scan_state_t;

	typedef struct packed {
		scan_state_t st;
		plan_t       plan;
	} step_t;

	function automatic step_t push_res(step_t s, logic [1:0] k, logic [7:0] v);
		if (s.plan.cnt != MAX_RES) begin
			s.plan.res[s.plan.cnt].kind  = k;
			s.plan.res[s.plan.cnt].value = v;
			s.plan.cnt = s.plan.cnt + 2'd1;
		end
		return s;
	endfunction

	function automatic step_t emit_byte(step_t s, logic [7:0] c);
		s = push_res(s, KIND_BYTE, c);
		s.st.topen = 1'b1;
		return s;
	endfunction

	function automatic step_t close_token(step_t s);
		if (s.st.topen) begin
			s = push_res(s, KIND_END, CH_NUL);
			s.st.topen = 1'b0;
		end
		return s;
	endfunction

	function automatic step_t end_line(step_t s, logic [1:0] status);
		s = push_res(s, status, CH_NUL);
		s.st.mode  = MODE_NORMAL;
		s.st.topen = 1'b0;
		return s;
	endfunction

	function automatic step_t scan_normal(step_t s, logic [7:0] c);
		s.st.mode = MODE_NORMAL;
		if (c == CH_NUL) begin
			s = close_token(s);
			s = end_line(s, KIND_LINE_OK);
		end else if (c == CH_SPACE) begin
			s = close_token(s);
		end else if (c == CH_PIPE) begin
			s = close_token(s);
			s = emit_byte(s, c);
			s = close_token(s);
		end else if (c == CH_LT || c == CH_GT) begin
			s = close_token(s);
			s = emit_byte(s, c);
			s.st.mode = (c == CH_LT) ? MODE_HELD_LT : MODE_HELD_GT;
		end else if (c == CH_DQUOTE) begin
			s = emit_byte(s, c);
			s.st.mode = MODE_DQ;
		end else if (c == CH_SQUOTE) begin
			s = emit_byte(s, c);
			s.st.mode = MODE_SQ;
		end else begin
			s = emit_byte(s, c);
		end
		return s;
	endfunction

	function automatic step_t tok_step(scan_state_t st, logic [7:0] c);
		step_t      s;
		logic [7:0] closer;
		logic [7:0] held;
		s      = '0;
		s.st   = st;
		closer = (st.mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE;
		held   = (st.mode == MODE_HELD_LT) ? CH_LT : CH_GT;
		unique case (st.mode) inside
			MODE_DQ, MODE_SQ: begin
				if (c == CH_NUL) begin
					s = end_line(s, KIND_UNTERM);
				end else begin
					s = emit_byte(s, c);
					if (c == closer) s.st.mode = MODE_AFTERQ;
				end
			end
			MODE_AFTERQ: begin
				if (c == CH_NUL || c == CH_SPACE || c == CH_GT) begin
					s = close_token(s);
					s = scan_normal(s, c);
				end else if (c == CH_DQUOTE) begin
					s = emit_byte(s, c);
					s.st.mode = MODE_DQ;
				end else if (c == CH_SQUOTE) begin
					s = emit_byte(s, c);
					s.st.mode = MODE_SQ;
				end else begin
					s = emit_byte(s, c);
				end
			end
			MODE_HELD_LT, MODE_HELD_GT: begin
				if (c == held) begin
					s = emit_byte(s, c);
					s = close_token(s);
					s.st.mode = MODE_NORMAL;
				end else begin
					s = close_token(s);
					s = scan_normal(s, c);
				end
			end
			default: begin
				s = scan_normal(s, c);
			end
		endcase
		return s;
	endfunction

endpackage

@@ rtl/slt_front.sv @@
module slt_front import slt_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  logic [7:0]  ch,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        q_full,
	output logic        q_push,
	output plan_t       q_data,
	output scan_state_t state
);

	scan_state_t state_q;
	step_t       step;
	logic        accept;

	assign step     = tok_step(state_q, ch);
	assign in_ready = !q_full;
	assign accept   = in_valid && in_ready;
	assign q_push   = accept && (step.plan.cnt != 2'd0);
	assign q_data   = step.plan;
	assign state    = state_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{mode: MODE_NORMAL, topen: 1'b0};
		end else if (accept) begin
			state_q <= step.st;
		end
	end

endmodule

@@ rtl/slt_queue.sv @@
module slt_queue import slt_pkg::*; #(
	parameter int DEPTH = 4
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  push,
	input  plan_t wdata,
	output logic  full,
	input  logic  pop,
	output logic  empty,
	output plan_t rdata
);

	localparam int PW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	plan_t         mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;
	logic          do_push;
	logic          do_pop;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign do_push = push && !full;
	assign do_pop  = pop && !empty;
	assign rdata   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_push) mem_q[wr_ptr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (do_pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (do_push && !do_pop)      count_q <= count_q + 1'b1;
			else if (do_pop && !do_push) count_q <= count_q - 1'b1;
		end
	end

endmodule

@@ rtl/slt_back.sv @@
module slt_back import slt_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       q_empty,
	input  plan_t      q_data,
	output logic       q_pop,
	output logic [1:0] kind,
	output logic [7:0] value,
	output logic       last,
	output logic       out_valid,
	input  logic       out_ready
);

	logic [1:0] idx_q;
	logic       load;
	logic       is_last;
	res_t       cur;

	assign load    = !out_valid || out_ready;
	assign cur     = q_data.res[idx_q];
	assign is_last = (idx_q == (q_data.cnt - 2'd1));
	assign q_pop   = load && !q_empty && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
			idx_q     <= '0;
		end else if (load) begin
			out_valid <= !q_empty;
			if (!q_empty) idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load && !q_empty) begin
			kind  <= cur.kind;
			value <= cur.value;
			last  <= is_last;
		end
	end

endmodule

@@ rtl/shell_line_tokenizer_unit.sv @@
// Shell line tokenizer.
// Input channel (ch, in_valid, in_ready): one command-line byte per transaction;
// a zero byte ends the line. Output channel (kind, value, last, out_valid,
// out_ready): token bytes, token-end markers and one line status per line.
// Each input byte yields zero to three output transactions; last marks the
// final one belonging to that byte. A space with no open token yields none.
// A byte is classified in the cycle it is accepted and its results are queued;
// results then pass through the queue and the output register and leave at
// one per cycle while out_ready is high. Sustained rate is one input per cycle
// while each byte yields at most one result and out_ready stays high; when the
// output port is the limit, input slows to match it.
// The queue holds QUEUE_DEPTH classified bytes; in_ready drops only when it is
// full, so input keeps flowing while the receiver stalls for a short time.
// When out_ready is low, the output register holds its transaction.
// Reset clears the scan state to normal scanning with no open token and
// empties the queue and output register.
module shell_line_tokenizer_unit import slt_pkg::*; #(
	parameter int QUEUE_DEPTH = 4
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [7:0] ch,
	input  logic       in_valid,
	output logic       in_ready,
	output logic [1:0] kind,
	output logic [7:0] value,
	output logic       last,
	output logic       out_valid,
	input  logic       out_ready
);

	logic        q_push;
	logic        q_pop;
	logic        q_full;
	logic        q_empty;
	plan_t       q_wdata;
	plan_t       q_rdata;
	scan_state_t scan_state;

	slt_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch       (ch),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.q_full   (q_full),
		.q_push   (q_push),
		.q_data   (q_wdata),
		.state    (scan_state)
	);

	slt_queue #(.DEPTH(QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  (q_wdata),
		.full   (q_full),
		.pop    (q_pop),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	slt_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.q_data    (q_rdata),
		.q_pop     (q_pop),
		.kind      (kind),
		.value     (value),
		.last      (last),
		.out_valid (out_valid),
		.out_ready (out_ready)
	);

	a_line_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready && (ch == CH_NUL) |=>
		(scan_state.mode == MODE_NORMAL) && !scan_state.topen)
		else $error("scan state not cleared after line end");

	a_status_is_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && ((kind == KIND_LINE_OK) || (kind == KIND_UNTERM)) |-> last)
		else $error("line status not marked last");

	a_value_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (kind != KIND_BYTE) |-> (value == 8'd0))
		else $error("marker carries nonzero value");

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_push |-> !q_full)
		else $error("queue push while full");

endmodule

@@ tb/shell_line_tokenizer_unit_test.sv @@
module shell_line_tokenizer_unit_test;
	import slt_pkg::*;

	localparam int CYCLE_LIMIT = 400000;

	typedef struct packed {
		logic [1:0] kind;
		logic [7:0] value;
		logic       last;
	} token_out_t;

	logic       clk;
	logic       arst_n;
	logic [7:0] ch;
	logic       in_valid;
	logic       in_ready;
	logic [1:0] kind;
	logic [7:0] value;
	logic       last;
	logic       out_valid;
	logic       out_ready;

	logic [2:0] lex_mode;
	logic       lex_open;
	token_out_t step_out[3];
	int         step_cnt;
	token_out_t pending_tokens[$];

	int fail_count    = 0;
	int bytes_sent    = 0;
	int cycle_count   = 0;
	int rx_hold_req   = 0;
	int rx_stall_left = 0;
	bit tx_eager      = 1'b0;
	bit rx_eager      = 1'b0;

	shell_line_tokenizer_unit i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.ch       (ch),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.kind     (kind),
		.value    (value),
		.last     (last),
		.out_valid(out_valid),
		.out_ready(out_ready)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic put_result(input logic [1:0] k, input logic [7:0] v);
		if (step_cnt < 3) begin
			step_out[step_cnt] = '{kind: k, value: v, last: 1'b0};
			step_cnt++;
		end
	endtask

	task automatic put_byte(input logic [7:0] c);
		put_result(KIND_BYTE, c);
		lex_open = 1'b1;
	endtask

	task automatic end_token();
		if (lex_open) begin
			put_result(KIND_END, CH_NUL);
			lex_open = 1'b0;
		end
	endtask

	task automatic finish_line(input logic [1:0] status);
		put_result(status, CH_NUL);
		lex_mode = MODE_NORMAL;
		lex_open = 1'b0;
	endtask

	task automatic scan_plain(input logic [7:0] c);
		lex_mode = MODE_NORMAL;
		if (c == CH_NUL) begin
			end_token();
			finish_line(KIND_LINE_OK);
		end else if (c == CH_SPACE) begin
			end_token();
		end else if (c == CH_PIPE) begin
			end_token();
			put_byte(c);
			end_token();
		end else if (c == CH_LT || c == CH_GT) begin
			end_token();
			put_byte(c);
			lex_mode = (c == CH_LT) ? MODE_HELD_LT : MODE_HELD_GT;
		end else if (c == CH_DQUOTE) begin
			put_byte(c);
			lex_mode = MODE_DQ;
		end else if (c == CH_SQUOTE) begin
			put_byte(c);
			lex_mode = MODE_SQ;
		end else begin
			put_byte(c);
		end
	endtask

	task automatic tokenize_byte(input logic [7:0] c);
		logic [7:0] closer;
		logic [7:0] held;
		token_out_t r;
		step_cnt = 0;
		closer   = (lex_mode == MODE_DQ) ? CH_DQUOTE : CH_SQUOTE;
		held     = (lex_mode == MODE_HELD_LT) ? CH_LT : CH_GT;
		case (lex_mode)
			MODE_DQ, MODE_SQ: begin
				if (c == CH_NUL) begin
					finish_line(KIND_UNTERM);
				end else begin
					put_byte(c);
					if (c == closer) lex_mode = MODE_AFTERQ;
				end
			end
			MODE_AFTERQ: begin
				if (c == CH_NUL || c == CH_SPACE || c == CH_GT) begin
					end_token();
					scan_plain(c);
				end else if (c == CH_DQUOTE) begin
					put_byte(c);
					lex_mode = MODE_DQ;
				end else if (c == CH_SQUOTE) begin
					put_byte(c);
					lex_mode = MODE_SQ;
				end else begin
					put_byte(c);
				end
			end
			MODE_HELD_LT, MODE_HELD_GT: begin
				if (c == held) begin
					put_byte(c);
					end_token();
					lex_mode = MODE_NORMAL;
				end else begin
					end_token();
					scan_plain(c);
				end
			end
			default: begin
				scan_plain(c);
			end
		endcase
		for (int i = 0; i < step_cnt; i++) begin
			r      = step_out[i];
			r.last = (i == step_cnt - 1);
			pending_tokens.push_back(r);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : token_check
		token_out_t want;
		if (!arst_n) begin
			lex_mode = MODE_NORMAL;
			lex_open = 1'b0;
		end else begin
			if (in_valid && in_ready) tokenize_byte(ch);
			if (out_valid && out_ready) begin
				if (pending_tokens.size() == 0) begin
					$error("unexpected transaction: kind %0d value %0h last %0b", kind, value, last);
					fail_count++;
				end else begin
					want = pending_tokens.pop_front();
					if (kind !== want.kind) begin
						$error("kind: expected %0d, actual %0d", want.kind, kind);
						fail_count++;
					end
					if (value !== want.value) begin
						$error("value: expected %0h, actual %0h", want.value, value);
						fail_count++;
					end
					if (last !== want.last) begin
						$error("last: expected %0b, actual %0b", want.last, last);
						fail_count++;
					end
				end
			end
		end
	end

	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85) return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	initial begin
		out_ready = 1'b0;
		forever begin
			@(posedge clk);
			if (rx_hold_req > 0) begin
				rx_stall_left = rx_hold_req - 1;
				rx_hold_req   = 0;
				out_ready <= 1'b0;
			end else if (rx_stall_left > 0) begin
				rx_stall_left--;
				out_ready <= 1'b0;
			end else if (!rx_eager && $urandom_range(0, 3) == 0) begin
				rx_stall_left = idle_len() - 1;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("tb: failure");
		$finish;
	end

	task automatic send_byte(input logic [7:0] c);
		int gap;
		gap = (!tx_eager && $urandom_range(0, 2) == 0) ? idle_len() : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		ch       <= c;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		bytes_sent++;
	endtask

	task automatic send_text(input string s);
		for (int i = 0; i < s.len(); i++) send_byte(s[i]);
	endtask

	task automatic wait_all_results();
		in_valid <= 1'b0;
		do @(posedge clk); while (pending_tokens.size() != 0);
		repeat (4) @(posedge clk);
	endtask

	function automatic logic [7:0] plain_byte();
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255));
		while (b inside {CH_SPACE, CH_PIPE, CH_LT, CH_GT, CH_DQUOTE, CH_SQUOTE});
		return b;
	endfunction

	function automatic logic [7:0] quoted_byte(input logic [7:0] q);
		logic [7:0] b;
		do b = 8'($urandom_range(1, 255));
		while (b == q);
		return b;
	endfunction

	task automatic test_words_and_operators();
		send_byte(CH_SPACE);
		send_byte(8'hFF);
		send_text("|<<>x ");
		send_byte(CH_NUL);
		send_byte(CH_LT);
		send_byte(CH_NUL);
	endtask

	task automatic test_quoting();
		send_byte(CH_DQUOTE);
		send_byte(8'h01);
		send_text("\"|'");
		send_byte(8'h80);
		send_text("'>>");
		send_byte(CH_NUL);
	endtask

	task automatic test_unclosed_quote();
		send_text("'q");
		send_byte(CH_NUL);
	endtask

	task automatic test_output_backpressure();
		tx_eager    = 1'b1;
		rx_hold_req = 250;
		repeat (15) send_text("<|");
		send_byte(CH_NUL);
		tx_eager = 1'b0;
		wait_all_results();
	endtask

	task automatic send_random_line();
		int         n_tok;
		int         sel;
		logic [7:0] q;
		tx_eager = ($urandom_range(0, 4) == 0);
		rx_eager = ($urandom_range(0, 4) == 0);
		if ($urandom_range(0, 9) == 0) begin
			repeat ($urandom_range(1, 8)) send_byte(8'($urandom_range(0, 255)));
			send_byte(CH_NUL);
			return;
		end
		n_tok = $urandom_range(0, 6);
		repeat (n_tok) begin
			if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 2)) send_byte(CH_SPACE);
			sel = $urandom_range(0, 9);
			if (sel < 4) begin
				repeat ($urandom_range(1, 4)) send_byte(plain_byte());
			end else if (sel < 7) begin
				repeat ($urandom_range(0, 2)) send_byte(plain_byte());
				q = $urandom_range(0, 1) ? CH_DQUOTE : CH_SQUOTE;
				send_byte(q);
				repeat ($urandom_range(0, 4)) send_byte(quoted_byte(q));
				if ($urandom_range(0, 11) == 0) begin
					send_byte(CH_NUL);
					return;
				end
				send_byte(q);
				repeat ($urandom_range(0, 2)) begin
					case ($urandom_range(0, 3))
						0: send_byte(CH_PIPE);
						1: send_byte(CH_LT);
						default: send_byte(plain_byte());
					endcase
				end
			end else begin
				case ($urandom_range(0, 5))
					0: send_text("|");
					1: send_text("<");
					2: send_text(">");
					3: send_text("<<");
					4: send_text(">>");
					default: send_text("<<<");
				endcase
			end
		end
		if ($urandom_range(0, 3) == 0) send_byte(CH_SPACE);
		send_byte(CH_NUL);
	endtask

	task automatic test_random_lines();
		int target;
		target = bytes_sent + 380;
		while (bytes_sent < target) send_random_line();
	endtask

	initial begin
		arst_n   = 1'b0;
		in_valid = 1'b0;
		ch       = CH_NUL;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_words_and_operators();
		test_quoting();
		test_unclosed_quote();
		wait_all_results();
		test_output_backpressure();
		test_random_lines();
		rx_eager = 1'b1;
		wait_all_results();
		repeat (20) @(posedge clk);
		if (fail_count == 0) begin
			$display("tb: success");
		end else begin
			$display("tb: failure");
		end
		$finish;
	end

endmodule

@@ files.f @@
rtl/slt_pkg.sv
rtl/slt_front.sv
rtl/slt_queue.sv
rtl/slt_back.sv
rtl/shell_line_tokenizer_unit.sv
tb/shell_line_tokenizer_unit_test.sv
